// ----- hdl/stm_pkg.sv -----
package stm_pkg;

    localparam int OPCODE_W   = 2;
    localparam int INDEX_W    = 10;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 11;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    // word index of each configuration register
    localparam int REG_ELEMENT_COUNT = 0;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_ANSWER = 2'd0,
        ST_DONE   = 2'd1,
        ST_BAD    = 2'd2
    } t_status;

    typedef struct packed {
        logic    latch;
        logic    write_item;
        logic    build_init;
        logic    build_rd;
        logic    lvl_next;
        logic    set_ready;
        logic    q_issue;
        logic    load_out;
        t_status kind;
    } t_dp_cmd;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                query_bad;
        logic                lvl_ok;
        logic                last_pos;
    } t_dp_stat;

endpackage

// ----- hdl/stm_if.sv -----
interface stm_in_if import stm_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic [INDEX_W-1:0]         left_index;
    logic [INDEX_W-1:0]         right_index;
    logic signed [VALUE_W-1:0]  element_value;

    modport source (
        output valid, opcode, left_index, right_index, element_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, left_index, right_index, element_value,
        output ready
    );
endinterface

interface stm_out_if import stm_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  minimum_value;
    logic [STATUS_W-1:0]        status;

    modport source (
        output valid, minimum_value, status,
        input  ready
    );
    modport sink (
        input  valid, minimum_value, status,
        output ready
    );
endinterface

// ----- hdl/stm_dp.sv -----
module stm_dp import stm_pkg::*; #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS       = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  logic                       i_cfg_wr,
    input  logic [COUNT_W-1:0]         i_element_count,
    input  logic [OPCODE_W-1:0]        i_opcode,
    input  logic [INDEX_W-1:0]         i_left_index,
    input  logic [INDEX_W-1:0]         i_right_index,
    input  logic signed [VALUE_W-1:0]  i_element_value,
    output logic signed [VALUE_W-1:0]  o_minimum_value,
    output logic [STATUS_W-1:0]        o_status
);

    localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int JW     = $clog2(LEVELS + 1);
    localparam int ADDR_W = LVL_W + IDX_W;
    localparam int DEPTH  = LEVELS * (2 ** IDX_W);
    localparam int LIVE_W = $clog2(MAX_ELEMENTS + 1);
    localparam int CW0    = (LIVE_W > COUNT_W) ? LIVE_W : COUNT_W;
    localparam int CW     = (CW0 > LEVELS) ? CW0 : LEVELS;
    localparam int LEN_W  = INDEX_W + 1;
    localparam int K_W    = $clog2(LEN_W);

    // request registers
    logic [OPCODE_W-1:0]        r_opcode;
    logic [INDEX_W-1:0]         r_left;
    logic [INDEX_W-1:0]         r_right;
    logic signed [VALUE_W-1:0]  r_value;

    logic                       r_table_ready;
    logic [JW-1:0]              r_j;
    logic [CW-1:0]              r_i;
    logic                       r_bw_en;
    logic [ADDR_W-1:0]          r_bw_addr;
    logic                       r_single;
    logic signed [VALUE_W-1:0]  r_rd_a;
    logic signed [VALUE_W-1:0]  r_rd_b;
    logic signed [VALUE_W-1:0]  r_min;
    logic [STATUS_W-1:0]        r_status;

    logic [VALUE_W-1:0]         mem [DEPTH];

    logic [CW-1:0]              live_cnt;
    logic [LEN_W-1:0]           len;
    logic [K_W-1:0]             k_raw;
    logic [LVL_W-1:0]           k_sel;
    logic [LEN_W-1:0]           pow2;
    logic [LEN_W-1:0]           q_pos_b;
    logic [CW-1:0]              span;
    logic [CW-1:0]              half;
    logic [LVL_W-1:0]           lvl_prev;
    logic signed [VALUE_W-1:0]  pair_min;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr_a;
    logic [ADDR_W-1:0]          rd_addr_b;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [VALUE_W-1:0]         wr_data;
    logic                       item_in_range;

    assign live_cnt = (CW'(i_element_count) > CW'(MAX_ELEMENTS)) ?
                      CW'(MAX_ELEMENTS) : CW'(i_element_count);

    // query geometry: k = position of the leading one of the length
    assign len = LEN_W'(r_right) - LEN_W'(r_left) + LEN_W'(1);

    always_comb begin
        k_raw = '0;
        for (int b = 0; b < LEN_W; b++) begin
            if (len[b]) begin
                k_raw = K_W'(b);
            end
        end
    end

    always_comb begin
        if (int'(k_raw) > LEVELS - 1) begin
            k_sel = LVL_W'(LEVELS - 1);
        end else begin
            k_sel = LVL_W'(k_raw);
        end
    end

    assign pow2    = LEN_W'(1) << k_sel;
    assign q_pos_b = LEN_W'(r_right) + LEN_W'(1) - pow2;

    // build geometry
    assign span     = CW'(1) << r_j;
    assign half     = span >> 1;
    assign lvl_prev = LVL_W'(r_j - JW'(1));

    assign o_stat.opcode    = r_opcode;
    assign o_stat.query_bad = (r_opcode != OP_QUERY) || !r_table_ready ||
                              (r_left > r_right) || (CW'(r_right) >= live_cnt);
    assign o_stat.lvl_ok    = (int'(r_j) < LEVELS) && (span <= live_cnt);
    assign o_stat.last_pos  = ({1'b0, r_i} + {1'b0, span}) >= {1'b0, live_cnt};

    assign pair_min = (r_rd_a <= r_rd_b) ? r_rd_a : r_rd_b;

    // table ports
    assign rd_en = i_cmd.q_issue || i_cmd.build_rd;

    always_comb begin
        if (i_cmd.q_issue) begin
            rd_addr_a = {k_sel, IDX_W'(r_left)};
            rd_addr_b = {k_sel, IDX_W'(q_pos_b)};
        end else begin
            rd_addr_a = {lvl_prev, IDX_W'(r_i)};
            rd_addr_b = {lvl_prev, IDX_W'(r_i + half)};
        end
    end

    assign item_in_range = CW'(r_left) < CW'(MAX_ELEMENTS);

    always_comb begin
        if (i_cmd.write_item) begin
            wr_en   = item_in_range;
            wr_addr = {LVL_W'(0), IDX_W'(r_left)};
            wr_data = r_value;
        end else begin
            wr_en   = r_bw_en;
            wr_addr = r_bw_addr;
            wr_data = pair_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_a <= mem[rd_addr_a];
            r_rd_b <= mem[rd_addr_b];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_opcode <= i_opcode;
            r_left   <= i_left_index;
            r_right  <= i_right_index;
            r_value  <= i_element_value;
        end
        if (i_cmd.build_rd) begin
            r_bw_addr <= {LVL_W'(r_j), IDX_W'(r_i)};
        end
        if (i_cmd.q_issue) begin
            r_single <= (pow2 == len);
        end
        if (i_cmd.load_out) begin
            r_status <= i_cmd.kind;
            if (i_cmd.kind == ST_ANSWER) begin
                r_min <= r_single ? r_rd_a : pair_min;
            end else begin
                r_min <= '0;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_ready <= 1'b0;
            r_j           <= JW'(1);
            r_i           <= '0;
            r_bw_en       <= 1'b0;
        end else begin
            r_bw_en <= i_cmd.build_rd;
            if (i_cfg_wr || i_cmd.write_item) begin
                r_table_ready <= 1'b0;
            end else if (i_cmd.set_ready) begin
                r_table_ready <= 1'b1;
            end
            if (i_cmd.build_init) begin
                r_j <= JW'(1);
                r_i <= '0;
            end else if (i_cmd.lvl_next) begin
                r_j <= r_j + JW'(1);
                r_i <= '0;
            end else if (i_cmd.build_rd) begin
                r_i <= r_i + CW'(1);
            end
        end
    end

    assign o_minimum_value = r_min;
    assign o_status        = r_status;

endmodule

// ----- hdl/stm_ctrl.sv -----
module stm_ctrl import stm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_BLVL,
        S_BRD,
        S_BDRAIN,
        S_FINISH
    } t_state;

    t_state  r_state;
    logic    r_out_valid;
    t_status r_kind;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_in_valid;
            end
            S_DECODE: begin
                case (i_stat.opcode)
                    OP_WRITE: o_cmd.write_item = 1'b1;
                    OP_BUILD: o_cmd.build_init = 1'b1;
                    default:  o_cmd.q_issue    = !i_stat.query_bad;
                endcase
            end
            S_BLVL: begin
                o_cmd.set_ready = !i_stat.lvl_ok;
            end
            S_BRD: begin
                o_cmd.build_rd = 1'b1;
            end
            S_BDRAIN: begin
                o_cmd.lvl_next = 1'b1;
            end
            S_FINISH: begin
                // result register is free or being emptied this cycle
                o_cmd.load_out = !r_out_valid || i_out_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_kind      <= ST_DONE;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    case (i_stat.opcode)
                        OP_WRITE: begin
                            r_kind  <= ST_DONE;
                            r_state <= S_FINISH;
                        end
                        OP_BUILD: begin
                            r_state <= S_BLVL;
                        end
                        default: begin
                            r_kind  <= i_stat.query_bad ? ST_BAD : ST_ANSWER;
                            r_state <= S_FINISH;
                        end
                    endcase
                end
                S_BLVL: begin
                    if (i_stat.lvl_ok) begin
                        r_state <= S_BRD;
                    end else begin
                        r_kind  <= ST_DONE;
                        r_state <= S_FINISH;
                    end
                end
                S_BRD: begin
                    if (i_stat.last_pos) begin
                        r_state <= S_BDRAIN;
                    end
                end
                S_BDRAIN: begin
                    // lets the last write of the level land before the next level reads it
                    r_state <= S_BLVL;
                end
                S_FINISH: begin
                    if (o_cmd.load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/sparse_table_range_min.sv -----
// Channel   Dir  Payload                                               Handshake
// i_req     in   opcode, left_index, right_index, element_value        valid/ready
// o_rsp     out  minimum_value, status                                 valid/ready
// apb       in   psel, penable, pwrite, paddr, pwdata -> prdata        pready tied high
//
// Write and query: each request passes accept, decode/table read and result load;
//   result load is its own step since the level table read is registered.
// Build: per level, a level check, entry reads and a drain, one entry per cycle
//   through the two table read ports.
// Reset is synchronous; the table is not cleared, only the built flag is.
// A result waiting on o_rsp does not block the next request from being accepted;
//   that request finishes and waits for the result register to empty.
module sparse_table_range_min import stm_pkg::*; #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS       = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    stm_in_if.sink                i_req,
    stm_out_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [COUNT_W-1:0] r_element_count;
    logic               cfg_wr;
    logic               reg_hit;
    t_dp_cmd            cmd;
    t_dp_stat           stat;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == (APB_ADDR_W-2)'(REG_ELEMENT_COUNT));
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? APB_DATA_W'(r_element_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_count <= COUNT_RESET;
        end else if (cfg_wr) begin
            r_element_count <= pwdata[COUNT_W-1:0];
        end
    end

    stm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    stm_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVELS       (LEVELS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_wr        (cfg_wr),
        .i_element_count (r_element_count),
        .i_opcode        (i_req.opcode),
        .i_left_index    (i_req.left_index),
        .i_right_index   (i_req.right_index),
        .i_element_value (i_req.element_value),
        .o_minimum_value (o_rsp.minimum_value),
        .o_status        (o_rsp.status)
    );

endmodule

// ----- hdl/stm_checker.sv -----
module stm_checker import stm_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic signed [VALUE_W-1:0] i_minimum_value,
    input logic [STATUS_W-1:0]       i_status
);

    logic [1:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // requests accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_zero_unless_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_ANSWER) |-> i_minimum_value == '0)
        else $error("non-answer result carries a nonzero minimum");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_minimum_value) && $stable(i_status))
        else $error("stalled result changed");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 2'd0)
        else $error("result without an outstanding request");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("request accepted while the previous one is in work");

endmodule

bind sparse_table_range_min stm_checker u_stm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_minimum_value (o_rsp.minimum_value),
    .i_status        (o_rsp.status)
);

// ----- dv/sparse_table_range_min_check.sv -----
module sparse_table_range_min_check import stm_pkg::*; #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS       = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    stm_in_if                     req_mon,
    stm_out_if                    rsp_mon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    o_pending,
    output int                    o_fail_count
);

    typedef struct packed {
        logic signed [VALUE_W-1:0] minimum_value;
        t_status                   status;
    } t_rmq_answer;

    localparam logic [APB_ADDR_W-1:0] COUNT_ADDR = APB_ADDR_W'(REG_ELEMENT_COUNT * 4);

    t_rmq_answer               answers_due_q[$];
    logic signed [VALUE_W-1:0] span_min [LEVELS][MAX_ELEMENTS];
    logic [COUNT_W-1:0]        elem_count;
    logic                      table_built;
    int                        fail_count = 0;

    assign o_fail_count = fail_count;

    initial o_pending = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch: %s got %08h expected %08h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic logic signed [VALUE_W-1:0] min_of(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b
    );
        return (a <= b) ? a : b;
    endfunction

    function automatic int usable_count();
        return (elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(elem_count);
    endfunction

    task automatic build_spans();
        int cnt;
        int half;
        cnt = usable_count();
        for (int j = 1; j < LEVELS && (1 << j) <= cnt; j++) begin
            half = 1 << (j - 1);
            for (int i = 0; i + 2 * half <= cnt; i++)
                span_min[j][i] = min_of(span_min[j-1][i], span_min[j-1][i+half]);
        end
        table_built = 1'b1;
    endtask

    task automatic predict_answer(input logic [OPCODE_W-1:0] op,
                                  input logic [INDEX_W-1:0] l,
                                  input logic [INDEX_W-1:0] r,
                                  input logic signed [VALUE_W-1:0] v,
                                  output t_rmq_answer ans);
        int lo;
        int hi;
        int len;
        int k;
        ans.minimum_value = '0;
        ans.status        = ST_DONE;
        lo = int'(l);
        hi = int'(r);
        case (op)
            OP_WRITE: begin
                if (lo < MAX_ELEMENTS)
                    span_min[0][lo] = v;
                table_built = 1'b0;
            end
            OP_BUILD: build_spans();
            default: begin
                // unknown opcode falls through as a bad query
                if (op != OP_QUERY || !table_built || lo > hi || hi >= usable_count()) begin
                    ans.status = ST_BAD;
                end else begin
                    len = hi - lo + 1;
                    k = 0;
                    while ((2 << k) <= len)
                        k++;
                    if (k > LEVELS - 1)
                        k = LEVELS - 1;
                    if ((1 << k) == len)
                        ans.minimum_value = span_min[k][lo];
                    else
                        ans.minimum_value = min_of(span_min[k][lo],
                                                   span_min[k][hi + 1 - (1 << k)]);
                    ans.status = ST_ANSWER;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_rmq_answer want;
        t_rmq_answer fresh;
        if (!i_rst_n) begin
            elem_count  = COUNT_RESET;
            table_built = 1'b0;
            answers_due_q.delete();
        end else begin
            if (psel && penable && pready && paddr == COUNT_ADDR) begin
                if (pwrite) begin
                    elem_count  = pwdata[COUNT_W-1:0];
                    table_built = 1'b0;
                end else if (prdata !== APB_DATA_W'(elem_count)) begin
                    flag_mismatch("element_count readback", prdata, APB_DATA_W'(elem_count));
                end
            end
            // responses first: one accepted on this edge belongs to an older request
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (answers_due_q.size() == 0) begin
                    flag_mismatch("response with nothing outstanding",
                                  rsp_mon.minimum_value, 32'h0);
                end else begin
                    want = answers_due_q.pop_front();
                    if (rsp_mon.status !== want.status)
                        flag_mismatch("status", 32'(rsp_mon.status), 32'(want.status));
                    if (rsp_mon.minimum_value !== want.minimum_value)
                        flag_mismatch("minimum_value", rsp_mon.minimum_value,
                                      want.minimum_value);
                end
            end
            if (req_mon.valid && req_mon.ready) begin
                predict_answer(req_mon.opcode, req_mon.left_index, req_mon.right_index,
                               req_mon.element_value, fresh);
                answers_due_q.push_back(fresh);
            end
        end
        o_pending <= answers_due_q.size();
    end

endmodule

// ----- dv/sparse_table_range_min_tb.sv -----
module sparse_table_range_min_tb;
    import stm_pkg::*;

    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 20;
    localparam int NUM_PHASES   = 8;
    // positions given a value up front; element counts the bench sets stay at or below this
    localparam int FILL         = 256;

    localparam logic [OPCODE_W-1:0]   OP_UNKNOWN = 2'd3;
    localparam logic [APB_ADDR_W-1:0] COUNT_ADDR = APB_ADDR_W'(REG_ELEMENT_COUNT * 4);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int pending;
    int fails;
    int cycle_count  = 0;
    int hold_trigger = 0;
    bit back_to_back = 1'b0;
    int live;
    int phase_count [NUM_PHASES] = '{1, 2, 0, FILL, 3, 0, 0, FILL - 1};

    stm_in_if  req_if ();
    stm_out_if rsp_if ();

    sparse_table_range_min #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVELS       (LEVELS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sparse_table_range_min_check #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVELS       (LEVELS)
    ) u_rmq_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req_mon      (req_if),
        .rsp_mon      (rsp_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_pending    (pending),
        .o_fail_count (fails)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // response side: random backpressure, plus a long hold when the stimulus asks
    initial begin : rsp_drive
        int roll;
        int n;
        int hold_seen;
        hold_seen = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            if (hold_trigger != hold_seen) begin
                hold_seen = hold_trigger;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 65) begin
                    rsp_if.ready <= 1'b1;
                    n = $urandom_range(1, 20);
                end else if (roll < 70) begin
                    rsp_if.ready <= 1'b1;
                    n = $urandom_range(100, 300);
                end else if (roll < 95) begin
                    rsp_if.ready <= 1'b0;
                    n = $urandom_range(1, 4);
                end else begin
                    rsp_if.ready <= 1'b0;
                    n = $urandom_range(20, 80);
                end
                // a hold request cuts the current stretch short
                for (int c = 0; c < n && hold_trigger == hold_seen; c++)
                    @(posedge i_clk);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        case (roll % 10)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic send_item(input logic [OPCODE_W-1:0] op, input int l, input int r,
                             input logic [VALUE_W-1:0] v);
        int gap;
        req_if.opcode        <= op;
        req_if.left_index    <= INDEX_W'(l);
        req_if.right_index   <= INDEX_W'(r);
        req_if.element_value <= v;
        req_if.valid         <= 1'b1;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        gap = back_to_back ? 0 : pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (!back_to_back && $urandom_range(0, 99) < 2)
            wait_drained();
    endtask

    task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= COUNT_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_element_count(input int c);
        wait_drained();
        repeat (4) @(posedge i_clk);
        apb_access(1'b1, APB_DATA_W'(c));
        apb_access(1'b0, '0);
        live = (c > MAX_ELEMENTS) ? MAX_ELEMENTS : c;
    endtask

    task automatic query_item(input int l, input int r);
        send_item(OP_QUERY, l, r, $urandom);
    endtask

    task automatic random_item(output int sent);
        int roll;
        int n;
        int l;
        int r;
        roll = $urandom_range(0, 99);
        sent = 1;
        if (roll < 12) begin
            // short burst of writes, usually followed by a rebuild
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                if (live > 0 && $urandom_range(0, 3) != 0)
                    l = $urandom_range(0, live - 1);
                else
                    l = $urandom_range(0, MAX_ELEMENTS - 1);
                send_item(OP_WRITE, l, $urandom_range(0, 1023), pick_value());
            end
            sent = n;
            if ($urandom_range(0, 9) < 8) begin
                send_item(OP_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
                sent++;
            end
        end else if (roll < 15) begin
            send_item(OP_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
        end else if (roll < 18) begin
            send_item(OP_UNKNOWN, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
        end else if (roll < 25 || live == 0) begin
            query_item($urandom_range(0, 1023), $urandom_range(0, 1023));
        end else begin
            l = $urandom_range(0, live - 1);
            if ($urandom_range(0, 1) == 0) begin
                r = l + $urandom_range(0, 15);
                if (r > live - 1)
                    r = live - 1;
            end else begin
                r = $urandom_range(l, live - 1);
            end
            query_item(l, r);
        end
    endtask

    initial begin : stimulus
        int done_items;
        int n;
        i_rst_n              <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.opcode        <= OP_WRITE;
        req_if.left_index    <= '0;
        req_if.right_index   <= '0;
        req_if.element_value <= '0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        live = MAX_ELEMENTS;
        phase_count[5] = $urandom_range(4, 40);
        phase_count[6] = $urandom_range(41, FILL - 2);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // stale table right out of reset, and the unknown opcode
        query_item(0, 1023);
        send_item(OP_UNKNOWN, 0, 0, '0);

        // every position in use gets a value so no build or query reads an empty slot
        set_element_count(FILL);
        for (int pos = 0; pos < FILL; pos++)
            send_item(OP_WRITE, pos, $urandom_range(0, 1023), pick_value());

        send_item(OP_BUILD, 0, 0, '0);
        query_item(0, FILL - 1);
        query_item(0, 0);
        query_item(FILL - 1, FILL - 1);
        query_item(0, FILL / 2 - 1);
        query_item(FILL / 2, FILL - 1);
        query_item(1, 200);
        query_item(10, 5);
        query_item(FILL - 1, 0);
        query_item(0, FILL);
        send_item(OP_WRITE, FILL - 1, 0, 32'h8000_0000);
        send_item(OP_WRITE, 0, 1023, 32'h7fff_ffff);
        query_item(0, FILL - 1);
        send_item(OP_BUILD, 1023, 1023, 32'hffff_ffff);
        query_item(0, FILL - 1);
        query_item(0, 0);
        query_item(FILL - 4, FILL - 1);
        query_item(0, 2);
        send_item(OP_UNKNOWN, 1023, 1023, 32'hffff_ffff);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_element_count(phase_count[ph]);
            if (ph == 4) begin
                // sender keeps offering while the response side holds off
                back_to_back = 1'b1;
                hold_trigger <= hold_trigger + 1;
            end
            query_item(0, 0);
            send_item(OP_BUILD, 0, 0, '0);
            done_items = 2;
            while (done_items < PHASE_ITEMS) begin
                random_item(n);
                done_items += n;
            end
            back_to_back = 1'b0;
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/stm_pkg.sv
hdl/stm_if.sv
hdl/stm_dp.sv
hdl/stm_ctrl.sv
hdl/sparse_table_range_min.sv
hdl/stm_checker.sv
dv/sparse_table_range_min_check.sv
dv/sparse_table_range_min_tb.sv
